>>> sv/ct_pkg.sv
// Shared types and constants of the connection table.
// Used by ct_store, ct_decide and the top level connection_table.
package ct_pkg;

  localparam int TABLE_ENTRIES = 16;

  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int HANDLE_W = 16;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  typedef logic [TABLE_ENTRIES-1:0] ent_vec_t;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_STAT   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RC_OK   = 2'd0,
    RC_MISS = 2'd1,
    RC_FULL = 2'd2
  } rc_t;

  typedef struct packed {
    action_t             action;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic [HANDLE_W-1:0] handle;
    logic                status;
  } req_t;

  typedef struct packed {
    ent_vec_t ap_hit;
    ent_vec_t handle_hit;
    ent_vec_t empty;
  } match_t;

  typedef struct packed {
    ent_vec_t            ins_sel;
    ent_vec_t            upd_sel;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic [HANDLE_W-1:0] handle;
    logic                status;
  } wr_cmd_t;

  typedef struct packed {
    logic                status;
    logic [HANDLE_W-1:0] handle;
    rc_t                 rc;
  } result_t;

  function automatic ent_vec_t lowest_one(input ent_vec_t v);
    return v & (~v + ent_vec_t'(1));
  endfunction

endpackage

>>> sv/connection_table.sv
// Top level of the connection table: input register, entry store, decision logic, result register.
// Depends on ct_pkg, ct_store and ct_decide.
//
//   channel  | ports     | fields (lowest bit first)
//   request  | in_*      | tuser: action; tdata: remote_addr, remote_port, handle, status_in
//   result   | out_*     | tdata: result_code, handle_out, status_out
//
// One request per cycle unless the result stalls; it goes via the input and result registers.
// The search over all entries and the priority pick settle between the input and result registers.
// The table is written at the same edge the result is registered, so the next request sees it.
// Reset empties every entry at once; no clearing pass is needed.
// A stalled result holds the input register, and in_tready drops only while both are full.
module connection_table
  import ct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // remote_addr, remote_port, handle, status_in, pad
  input  logic [IN_USER_W-1:0]  in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // result_code, handle_out, status_out, pad
);

  logic    in_valid_r;
  logic    in_valid_nxt;
  req_t    req_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t res_r;
  logic    advance;
  match_t  match;
  wr_cmd_t wr;
  result_t result;
  logic [TABLE_ENTRIES-1:0][HANDLE_W-1:0] entry_handle;
  ent_vec_t entry_status;

  assign advance       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready     = !in_valid_r || advance;
  assign in_valid_nxt  = (in_tvalid && in_tready) || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r.action <= action_t'(in_tuser);
      req_r.addr   <= in_tdata[ADDR_W-1:0];
      req_r.port   <= in_tdata[ADDR_W+PORT_W-1:ADDR_W];
      req_r.handle <= in_tdata[ADDR_W+PORT_W+HANDLE_W-1:ADDR_W+PORT_W];
      req_r.status <= in_tdata[ADDR_W+PORT_W+HANDLE_W];
    end
    if (advance) begin
      res_r <= result;
    end
  end

  ct_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req_r),
    .wr           (wr),
    .match        (match),
    .entry_handle (entry_handle),
    .entry_status (entry_status)
  );

  ct_decide u_decide (
    .fire         (advance),
    .req          (req_r),
    .match        (match),
    .entry_handle (entry_handle),
    .entry_status (entry_status),
    .result       (result),
    .wr           (wr)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - HANDLE_W - 3){1'b0}}, res_r.status, res_r.handle,
                       res_r.rc};

  a_rc_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.rc == RC_OK || res_r.rc == RC_MISS || res_r.rc == RC_FULL))
    else $error("result code outside the defined set");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.rc != RC_OK) |-> (res_r.handle == '0 && res_r.status == 1'b0))
    else $error("payload not zero on a failed request");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && req_r.action == ACT_INSERT && |match.empty) |=>
      (out_valid_r && res_r.rc == RC_OK))
    else $error("insert with a free entry did not succeed");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while the result register is empty");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr.ins_sel | wr.upd_sel) && !(in_valid_r == 1'b0 && (|(wr.ins_sel | wr.upd_sel))))
    else $error("table written by more than one entry or without a request");

endmodule

>>> sv/ct_store.sv
// Entry registers of the connection table with one comparator set per entry.
// Depends on ct_pkg for the entry count, request and write command types.
module ct_store
  import ct_pkg::*;
(
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  req_t                                    req,
  input  wr_cmd_t                                 wr,
  output match_t                                  match,
  output logic [TABLE_ENTRIES-1:0][HANDLE_W-1:0]  entry_handle,
  output ent_vec_t                                entry_status
);

  logic [TABLE_ENTRIES-1:0][ADDR_W-1:0]   entry_addr_r;
  logic [TABLE_ENTRIES-1:0][PORT_W-1:0]   entry_port_r;
  logic [TABLE_ENTRIES-1:0][HANDLE_W-1:0] entry_handle_r;
  ent_vec_t                               entry_status_r;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match.empty[i]      = (entry_addr_r[i] == '0);
      match.ap_hit[i]     = !match.empty[i] && (entry_addr_r[i] == req.addr) &&
                            (entry_port_r[i] == req.port);
      match.handle_hit[i] = !match.empty[i] && (entry_handle_r[i] == req.handle);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_addr_r <= '0;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (wr.ins_sel[i]) begin
          entry_addr_r[i] <= wr.addr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_port_r   <= '0;
      entry_handle_r <= '0;
      entry_status_r <= '0;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (wr.ins_sel[i]) begin
          entry_port_r[i]   <= wr.port;
          entry_handle_r[i] <= wr.handle;
          entry_status_r[i] <= wr.status;
        end else if (wr.upd_sel[i]) begin
          entry_port_r[i]   <= wr.port;
          entry_status_r[i] <= 1'b1;
        end
      end
    end
  end

  assign entry_handle = entry_handle_r;
  assign entry_status = entry_status_r;

endmodule

>>> sv/ct_decide.sv
// Picks the lowest matching entry for the request, forms the result and the write command.
// Depends on ct_pkg for the action and result codes and the shared structs.
module ct_decide
  import ct_pkg::*;
(
  input  logic                                    fire,
  input  req_t                                    req,
  input  match_t                                  match,
  input  logic [TABLE_ENTRIES-1:0][HANDLE_W-1:0]  entry_handle,
  input  ent_vec_t                                entry_status,
  output result_t                                 result,
  output wr_cmd_t                                 wr
);

  ent_vec_t            cand;
  ent_vec_t            pick;
  logic                found;
  logic [HANDLE_W-1:0] handle_sel;
  logic                status_sel;

  always_comb begin
    case (req.action)
      ACT_LOOKUP: cand = match.ap_hit;
      ACT_INSERT: cand = match.empty;
      default:    cand = match.handle_hit;
    endcase
    pick  = lowest_one(cand);
    found = |cand;
  end

  always_comb begin
    handle_sel = '0;
    status_sel = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (pick[i]) begin
        handle_sel = handle_sel | entry_handle[i];
        status_sel = status_sel | entry_status[i];
      end
    end
  end

  always_comb begin
    result.rc     = found ? RC_OK : RC_MISS;
    result.handle = '0;
    result.status = 1'b0;
    wr.ins_sel    = '0;
    wr.upd_sel    = '0;
    wr.addr       = req.addr;
    wr.port       = req.port;
    wr.handle     = req.handle;
    wr.status     = req.status;
    case (req.action)
      ACT_LOOKUP: begin
        if (found) begin
          result.handle = handle_sel;
        end
      end
      ACT_INSERT: begin
        if (!found) begin
          result.rc = RC_FULL;
        end
        if (fire) begin
          wr.ins_sel = pick;
        end
      end
      ACT_UPDATE: begin
        if (fire) begin
          wr.upd_sel = pick;
        end
      end
      default: begin
        if (found) begin
          result.status = status_sel;
        end
      end
    endcase
  end

endmodule
